// File: design/dsk_elv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsk_elv_pkg
// Shared types for the elevator disk scheduler: channel words, result codes,
// controller states and the command/status bundles between ctrl and datapath.
// ----------------------------------------------------------------------------
package dsk_elv_pkg;

  localparam int unsigned TRACK_W = 16;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned KEY_W   = TRACK_W + ID_W;
  localparam int unsigned INFO_W  = 1 + 8 + 12 + 32;

  typedef enum logic [1:0] {
    STS_QUEUED     = 2'd0,
    STS_REJECTED   = 2'd1,
    STS_DISPATCHED = 2'd2,
    STS_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    MODE_ENQUEUE  = 1'b0,
    MODE_DISPATCH = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [1:0]  unit;
    logic [5:0]  requester_id;
    logic        is_write;
    logic [15:0] track;
    logic [7:0]  first_sector;
    logic [11:0] sec_cnt;
    logic [31:0] buffer_address;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  out_requester_id;
    logic        out_is_write;
    logic [15:0] out_track;
    logic [7:0]  out_first_sector;
    logic [11:0] out_sec_cnt;
    logic [31:0] out_buffer_address;
    logic        moving_up;
  } out_word_t;

  typedef enum logic [1:0] {
    RES_REJECT,
    RES_ENQUEUE,
    RES_EMPTY,
    RES_DISPATCH
  } res_sel_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ENQ_CHK,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_PICK,
    ST_PICK_RD
  } ctrl_state_e;

  typedef struct packed {
    logic     load_in;
    logic     scan_start;
    logic     scan_step;
    logic     clr_step;
    logic     out_load;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_bad;
    logic mode_disp;
    logic scan_last;
    logic clr_last;
    logic any_found;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/dsk_elv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsk_elv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dsk_elv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/dsk_elv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsk_elv_ctrl
// Sequencer: clearing pass, enqueue check, slot scan and dispatch.
// ----------------------------------------------------------------------------
module dsk_elv_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  dsk_elv_pkg::dp_status_t status_i,
  output dsk_elv_pkg::dp_cmd_t    cmd_o
);
  import dsk_elv_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.unit_bad) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_sel  = RES_REJECT;
            state_d        = ST_IDLE;
          end
        end else if (status_i.mode_disp) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_ENQ_CHK;
        end
      end
      ST_ENQ_CHK: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = RES_ENQUEUE;
          state_d        = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_d = ST_PICK;
      ST_PICK: begin
        if (status_i.any_found) begin
          state_d = ST_PICK_RD;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = RES_EMPTY;
          state_d        = ST_IDLE;
        end
      end
      ST_PICK_RD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = RES_DISPATCH;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: design/dsk_elv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsk_elv_dp
// Datapath: pending tables in RAM, scan comparators, per-unit scan state,
// config register and the output register.
// ----------------------------------------------------------------------------
module dsk_elv_dp #(
  parameter int unsigned QUEUE_DEPTH       = 64,
  parameter int unsigned UNIT_COUNT        = 2,
  parameter int unsigned SECTORS_PER_TRACK = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dsk_elv_pkg::in_word_t   in_word_i,
  input  logic                    cfg_we_i,
  input  logic [15:0]             cfg_data_i,
  input  dsk_elv_pkg::dp_cmd_t    cmd_i,
  output dsk_elv_pkg::dp_status_t status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output dsk_elv_pkg::out_word_t  out_word_o
);
  import dsk_elv_pkg::*;

  localparam int unsigned SW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned UW    = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
  localparam int unsigned AW    = UW + SW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned UN    = 2 ** UW;
  localparam int unsigned ROW_W = 1 + TRACK_W;

  in_word_t            in_q;
  logic [15:0]         track_count_q;
  logic [AW-1:0]       clr_cnt_q;
  logic [SW-1:0]       scan_cnt_q;
  logic                scan_v_q;
  logic [SW-1:0]       scan_idx_q;
  logic                best_f_q, alt_f_q;
  logic [KEY_W-1:0]    best_k_q, alt_k_q;
  logic [TRACK_W-1:0]  last_track_q [UN];
  logic [ID_W-1:0]     last_id_q    [UN];
  logic                last_valid_q [UN];
  logic                dir_up_q     [UN];
  logic                out_valid_q;
  out_word_t           out_q, res;

  logic [UW-1:0]       u;
  logic [SW-1:0]       in_slot, sel_slot;
  logic [KEY_W-1:0]    sel_key, k, lk;
  logic                flip, enq_ok, out_free;
  logic                row_we, info_we;
  logic [AW-1:0]       row_waddr, row_raddr, info_addr;
  logic [ROW_W-1:0]    row_wdata, row_rdata;
  logic [INFO_W-1:0]   info_rdata;

  assign u        = in_q.unit[UW-1:0];
  assign in_slot  = SW'(in_q.requester_id);
  assign sel_key  = best_f_q ? best_k_q : alt_k_q;
  assign sel_slot = SW'(sel_key[ID_W-1:0]);
  assign flip     = !best_f_q;
  assign out_free = !out_valid_q || !out_stall_i;

  assign enq_ok = (in_q.track < track_count_q)
               && (32'(in_q.first_sector) < 32'(SECTORS_PER_TRACK))
               && (32'(in_q.requester_id) < 32'(QUEUE_DEPTH))
               && !row_rdata[ROW_W-1];

  assign status_o.unit_bad  = !(32'(in_q.unit) < 32'(UNIT_COUNT));
  assign status_o.mode_disp = (in_q.mode == MODE_DISPATCH);
  assign status_o.scan_last = (scan_cnt_q == SW'(QUEUE_DEPTH - 1));
  assign status_o.clr_last  = (clr_cnt_q == AW'(DEPTH - 1));
  assign status_o.any_found = best_f_q || alt_f_q;
  assign status_o.out_free  = out_free;

  // table row write: clear, insert on accepted enqueue, free on dispatch
  always_comb begin
    row_we    = 1'b0;
    row_waddr = {u, in_slot};
    row_wdata = {1'b1, in_q.track};
    info_we   = 1'b0;
    if (cmd_i.clr_step) begin
      row_we    = 1'b1;
      row_waddr = clr_cnt_q;
      row_wdata = '0;
    end else if (cmd_i.out_load && cmd_i.res_sel == RES_ENQUEUE && enq_ok) begin
      row_we  = 1'b1;
      info_we = 1'b1;
    end else if (cmd_i.out_load && cmd_i.res_sel == RES_DISPATCH) begin
      row_we    = 1'b1;
      row_waddr = {u, sel_slot};
      row_wdata = '0;
    end
  end

  assign row_raddr = cmd_i.scan_step ? {u, scan_cnt_q} : {u, in_slot};
  assign info_addr = {u, sel_slot};

  dsk_elv_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  dsk_elv_ram #(.WIDTH(INFO_W), .DEPTH(DEPTH)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i ({u, in_slot}),
    .wdata_i ({in_q.is_write, in_q.first_sector, in_q.sec_cnt,
               in_q.buffer_address}),
    .raddr_i (info_addr),
    .rdata_o (info_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_count_q <= '0;
      clr_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        track_count_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  assign k  = {row_rdata[TRACK_W-1:0], ID_W'(scan_idx_q)};
  assign lk = {last_track_q[u], last_id_q[u]};

  // scan: one slot per cycle, track the best key ahead and the turnaround key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      scan_v_q   <= 1'b0;
      scan_idx_q <= '0;
      best_f_q   <= 1'b0;
      alt_f_q    <= 1'b0;
      best_k_q   <= '0;
      alt_k_q    <= '0;
    end else begin
      scan_v_q   <= cmd_i.scan_step;
      scan_idx_q <= scan_cnt_q;
      if (cmd_i.scan_start) begin
        scan_cnt_q <= '0;
        best_f_q   <= 1'b0;
        alt_f_q    <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          scan_cnt_q <= scan_cnt_q + SW'(1);
        end
        if (scan_v_q && row_rdata[ROW_W-1]) begin
          if (!last_valid_q[u]) begin
            if (!best_f_q || k < best_k_q) begin
              best_f_q <= 1'b1;
              best_k_q <= k;
            end
          end else if (dir_up_q[u]) begin
            if (k > lk) begin
              if (!best_f_q || k < best_k_q) begin
                best_f_q <= 1'b1;
                best_k_q <= k;
              end
            end else if (!alt_f_q || k > alt_k_q) begin
              alt_f_q <= 1'b1;
              alt_k_q <= k;
            end
          end else begin
            if (k < lk) begin
              if (!best_f_q || k > best_k_q) begin
                best_f_q <= 1'b1;
                best_k_q <= k;
              end
            end else if (!alt_f_q || k < alt_k_q) begin
              alt_f_q <= 1'b1;
              alt_k_q <= k;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(UN); i++) begin
        last_track_q[i] <= '0;
        last_id_q[i]    <= '0;
        last_valid_q[i] <= 1'b0;
        dir_up_q[i]     <= 1'b1;
      end
    end else if (cmd_i.out_load && cmd_i.res_sel == RES_DISPATCH) begin
      last_track_q[u] <= sel_key[KEY_W-1:ID_W];
      last_id_q[u]    <= sel_key[ID_W-1:0];
      last_valid_q[u] <= 1'b1;
      dir_up_q[u]     <= dir_up_q[u] ^ flip;
    end
  end

  always_comb begin
    res = '0;
    case (cmd_i.res_sel)
      RES_REJECT:  res.status = STS_REJECTED;
      RES_ENQUEUE: res.status = enq_ok ? STS_QUEUED : STS_REJECTED;
      RES_EMPTY:   res.status = STS_EMPTY;
      RES_DISPATCH: begin
        res.status             = STS_DISPATCHED;
        res.out_requester_id   = sel_key[ID_W-1:0];
        res.out_track          = sel_key[KEY_W-1:ID_W];
        {res.out_is_write, res.out_first_sector, res.out_sec_cnt,
         res.out_buffer_address} = info_rdata;
        res.moving_up          = dir_up_q[u] ^ flip;
      end
      default: res.status = STS_REJECTED;
    endcase
  end

  // output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: design/disk_elevator_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_elevator_scheduler_core
// Per-unit elevator scan scheduler for disk read and write requests.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-------------
//  in      | input     | in_valid_i / in_stall_o | in_word_t
//  out     | output    | out_valid_o / out_stall_i | out_word_t
//  cfg     | input     | cfg_valid_i / cfg_ready_o | track_count
//
// Enqueue: the word is decoded and its slot read, then checked, and the result
// is registered; a bad unit is answered straight from the decode step.
// Dispatch: the slot table is read one slot per cycle on its single read port,
// then the chosen entry's info is read, which an empty unit skips.
// After reset a clearing pass over all 2**(unit bits + slot bits) rows (128 at
// the defaults) empties the tables; no word is accepted meanwhile.
// One word is in flight at a time; the next is accepted in the cycle after its
// result is loaded, and a result waiting in the output register holds the
// following one back.
// ----------------------------------------------------------------------------
module disk_elevator_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH       = 64,
  parameter int unsigned UNIT_COUNT        = 2,
  parameter int unsigned SECTORS_PER_TRACK = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  dsk_elv_pkg::in_word_t  in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output dsk_elv_pkg::out_word_t out_word_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [15:0]            cfg_data_i
);
  import dsk_elv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready_o = 1'b1;

  dsk_elv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  dsk_elv_dp #(
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .UNIT_COUNT        (UNIT_COUNT),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over a waiting result");

  a_nondisp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != STS_DISPATCHED) |->
      (out_word_o.out_track == '0 && out_word_o.out_requester_id == '0 &&
       out_word_o.moving_up == 1'b0))
    else $error("non-dispatch result carries request fields");

  a_idle_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!cmd.scan_step && !cmd.clr_step && !cmd.out_load))
    else $error("accepting while busy");

endmodule
